// File: hw/rtl/gain_ramp_mix_accumulator_defines.svh
// Assertion macros for the gain ramp mix accumulator checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef GAIN_RAMP_MIX_ACCUMULATOR_DEFINES_SVH
`define GAIN_RAMP_MIX_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GRMA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GRMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/grma_pkg.sv
// Shared types and constants for the gain ramp mix accumulator.
// Used by the controller, the datapath, the top level and the checker.
package grma_pkg;

  // Field widths of the stream payloads.
  localparam int FUNC_W   = 2;
  localparam int GAIN_W   = 13;
  localparam int COUNT_W  = 10;
  localparam int SAMPLE_W = 16;
  localparam int MIX_W    = 32;
  localparam int POS_W    = 9;

  // Input tdata layout, lowest field first.
  localparam int GSL_LSB    = 0;
  localparam int GEL_LSB    = GSL_LSB + GAIN_W;
  localparam int GSR_LSB    = GEL_LSB + GAIN_W;
  localparam int GER_LSB    = GSR_LSB + GAIN_W;
  localparam int COUNT_LSB  = GER_LSB + GAIN_W;
  localparam int STEREO_LSB = COUNT_LSB + COUNT_W;
  localparam int SL_LSB     = STEREO_LSB + 1;
  localparam int SR_LSB     = SL_LSB + SAMPLE_W;
  localparam int IN_USED_W  = SR_LSB + SAMPLE_W;
  localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;
  localparam int IN_TUSER_W = FUNC_W;

  // Output tdata layout, lowest field first.
  localparam int ML_LSB      = 0;
  localparam int MR_LSB      = ML_LSB + MIX_W;
  localparam int POS_LSB     = MR_LSB + MIX_W;
  localparam int OUT_USED_W  = POS_LSB + POS_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // Item kinds carried in tuser.
  localparam logic [FUNC_W-1:0] FUNC_BEGIN = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MIX   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MIX,
    ST_DIV_L_GO,
    ST_DIV_L_WAIT,
    ST_DIV_R_GO,
    ST_DIV_R_WAIT
  } ctrl_state_e;

  typedef struct packed {
    logic clr_write;
    logic begin_load;
    logic mix_issue;
    logic mix_commit;
    logic div_start;
    logic div_right;
    logic step_store;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
    logic out_free;
    logic div_done;
    logic clr_last;
    logic stereo;
  } dp_status_t;

endpackage

// File: hw/rtl/gain_ramp_mix_accumulator.sv
// Top level of the gain ramp mix accumulator: stream ports, controller and datapath.
// Depends on grma_pkg, grma_ctrl and grma_datapath.
//
//   Channel  Direction  Handshake                    Payload
//   s_axis   in         s_axis_tvalid/s_axis_tready  s_axis_tdata, s_axis_tuser (item kind)
//   m_axis   out        m_axis_tvalid/m_axis_tready  m_axis_tdata
//
// A mix item is accepted with the store read and multiply, then accumulated and written back.
// A begin item loads the chunk, then runs one division per channel (left, and right in stereo),
// each on the shared one-bit-per-cycle divider.
// A clear item, and the sweep after reset, zero the whole store with s_axis_tready low.
// A result waits in the output register; the next item is accepted meanwhile, and only a
// further frame's accumulate step waits for m_axis_tready.
module gain_ramp_mix_accumulator #(
  parameter int PACKET_FRAMES = 512,
  parameter int UNITY_GAIN    = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // gain_start_left, gain_end_left, gain_start_right, gain_end_right, frame_count,
  // stereo, sample_left, sample_right
  input  logic [grma_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // func
  input  logic [grma_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // mix_left, mix_right, frame_position
  output logic [grma_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  import grma_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  grma_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .func_i    (s_axis_tuser[FUNC_W-1:0]),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  grma_datapath #(
    .PACKET_FRAMES(PACKET_FRAMES),
    .UNITY_GAIN   (UNITY_GAIN)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (s_axis_tdata),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

// File: hw/rtl/grma_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module grma_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/grma_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No package dependencies; used by the datapath for the ramp steps.
module grma_divider #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W:0]   rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   rem_shift;
  logic             last;

  // The numerator shifts out of the top of quo_q while quotient bits enter below.
  assign rem_shift = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
  assign last      = (cnt_q == CNT_W'(NUM_W - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      if (rem_shift >= {1'b0, den_q}) begin
        rem_d = rem_shift - {1'b0, den_q};
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_shift;
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: hw/rtl/grma_datapath.sv
// Datapath: chunk registers, gain ramps, multipliers, saturating adders,
// accumulator store and output register. Depends on grma_pkg, grma_ram, grma_divider.
module grma_datapath #(
  parameter int PACKET_FRAMES = 512,
  parameter int UNITY_GAIN    = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  grma_pkg::dp_cmd_t                   cmd_i,
  output grma_pkg::dp_status_t                status_o,
  input  logic [grma_pkg::IN_TDATA_W-1:0]     in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [grma_pkg::OUT_TDATA_W-1:0]    out_data_o
);

  import grma_pkg::*;

  localparam int AW  = $clog2(PACKET_FRAMES);
  localparam int NW  = $clog2(PACKET_FRAMES + 1);
  localparam int GW  = $clog2(UNITY_GAIN + 1);
  localparam int QW  = GW + 16;
  localparam int RW  = GW + 17;
  localparam int PW  = GW + 17;
  localparam int CW  = (GAIN_W > GW) ? GAIN_W : GW;
  localparam int CNW = (COUNT_W > NW) ? COUNT_W : NW;

  function automatic logic [GW-1:0] clamp_gain(logic [GAIN_W-1:0] g);
    logic [CW-1:0] ge;
    ge = CW'(g);
    return (ge > CW'(UNITY_GAIN)) ? GW'(UNITY_GAIN) : GW'(ge);
  endfunction

  function automatic logic [MIX_W-1:0] sat_mix(logic signed [MIX_W:0] s);
    logic [MIX_W-1:0] r;
    if (s[MIX_W] != s[MIX_W-1]) begin
      r = s[MIX_W] ? {1'b1, {(MIX_W-1){1'b0}}} : {1'b0, {(MIX_W-1){1'b1}}};
    end else begin
      r = s[MIX_W-1:0];
    end
    return r;
  endfunction

  // Input fields.
  logic [GAIN_W-1:0]          in_gsl, in_gel, in_gsr, in_ger;
  logic [COUNT_W-1:0]         in_count;
  logic                       in_stereo;
  logic signed [SAMPLE_W-1:0] in_sl, in_sr;
  logic [CNW-1:0]             count_ext;

  assign in_gsl    = in_data_i[GSL_LSB +: GAIN_W];
  assign in_gel    = in_data_i[GEL_LSB +: GAIN_W];
  assign in_gsr    = in_data_i[GSR_LSB +: GAIN_W];
  assign in_ger    = in_data_i[GER_LSB +: GAIN_W];
  assign in_count  = in_data_i[COUNT_LSB +: COUNT_W];
  assign in_stereo = in_data_i[STEREO_LSB];
  assign in_sl     = $signed(in_data_i[SL_LSB +: SAMPLE_W]);
  assign in_sr     = $signed(in_data_i[SR_LSB +: SAMPLE_W]);
  assign count_ext = CNW'(in_count);

  // Chunk state.
  logic                 stereo_q, stereo_d;
  logic [NW-1:0]        chunk_len_q, chunk_len_d;
  logic [NW-1:0]        frame_idx_q, frame_idx_d;
  logic [GW-1:0]        gl0_q, gl0_d, gl1_q, gl1_d, gr0_q, gr0_d, gr1_q, gr1_d;
  logic signed [RW-1:0] ramp_l_q, ramp_l_d, ramp_r_q, ramp_r_d;
  logic signed [QW:0]   step_l_q, step_l_d, step_r_q, step_r_d;
  logic                 div_neg_q, div_neg_d;

  // Frame pipeline.
  logic signed [PW-1:0] prod_l_q, prod_l_d, prod_r_q, prod_r_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic [AW-1:0]        clr_addr_q, clr_addr_d;

  // Divider operands, chosen by channel.
  logic [GW-1:0]         div_g0, div_g1;
  logic signed [GW:0]    gain_diff;
  logic [GW-1:0]         diff_mag;
  logic                  div_done;
  logic [QW-1:0]         div_quo;
  logic signed [QW:0]    quo_s, step_res;

  assign div_g0    = cmd_i.div_right ? gr0_q : gl0_q;
  assign div_g1    = cmd_i.div_right ? gr1_q : gl1_q;
  assign gain_diff = $signed({1'b0, div_g1}) - $signed({1'b0, div_g0});
  assign diff_mag  = gain_diff[GW] ? GW'(-gain_diff) : GW'(gain_diff);
  assign quo_s     = $signed({1'b0, div_quo});
  assign step_res  = (chunk_len_q == '0) ? '0 : (div_neg_q ? -quo_s : quo_s);

  grma_divider #(
    .NUM_W(QW),
    .DEN_W(NW)
  ) u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  ({diff_mag, 16'h0000}),
    .den_i  (chunk_len_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Accumulator store: right sum in the upper half, left sum in the lower half.
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [2*MIX_W-1:0]     ram_wdata, ram_rdata;
  logic signed [MIX_W:0]  sum_l, sum_r;
  logic [MIX_W-1:0]       sat_l, sat_r;
  logic [GW-1:0]          gain_l, gain_r;
  logic signed [SAMPLE_W-1:0] samp_r;

  assign sum_l = (MIX_W+1)'($signed(ram_rdata[MIX_W-1:0])) + (MIX_W+1)'(prod_l_q);
  assign sum_r = (MIX_W+1)'($signed(ram_rdata[2*MIX_W-1:MIX_W])) + (MIX_W+1)'(prod_r_q);
  assign sat_l = sat_mix(sum_l);
  assign sat_r = sat_mix(sum_r);

  assign ram_we    = cmd_i.clr_write | cmd_i.mix_commit;
  assign ram_waddr = cmd_i.clr_write ? clr_addr_q : idx_q;
  assign ram_wdata = cmd_i.clr_write ? '0 : {sat_r, sat_l};

  grma_ram #(
    .WIDTH(2 * MIX_W),
    .DEPTH(PACKET_FRAMES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.mix_issue),
    .raddr_i(frame_idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // Ramps are never negative, so the gain is the integer part of the signed (GW+1).16 value.
  assign gain_l = ramp_l_q[16 +: GW];
  assign gain_r = ramp_r_q[16 +: GW];
  assign samp_r = stereo_q ? in_sr : in_sl;

  always_comb begin
    stereo_d    = stereo_q;
    chunk_len_d = chunk_len_q;
    frame_idx_d = frame_idx_q;
    gl0_d       = gl0_q;
    gl1_d       = gl1_q;
    gr0_d       = gr0_q;
    gr1_d       = gr1_q;
    ramp_l_d    = ramp_l_q;
    ramp_r_d    = ramp_r_q;
    step_l_d    = step_l_q;
    step_r_d    = step_r_q;
    div_neg_d   = div_neg_q;
    prod_l_d    = prod_l_q;
    prod_r_d    = prod_r_q;
    idx_d       = idx_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    clr_addr_d  = clr_addr_q;

    if (cmd_i.clr_write) begin
      clr_addr_d = (clr_addr_q == AW'(PACKET_FRAMES - 1)) ? '0 : clr_addr_q + AW'(1);
    end

    if (cmd_i.begin_load) begin
      gl0_d       = clamp_gain(in_gsl);
      gl1_d       = clamp_gain(in_gel);
      gr0_d       = in_stereo ? clamp_gain(in_gsr) : clamp_gain(in_gsl);
      gr1_d       = in_stereo ? clamp_gain(in_ger) : clamp_gain(in_gel);
      stereo_d    = in_stereo;
      chunk_len_d = (count_ext > CNW'(PACKET_FRAMES)) ? NW'(PACKET_FRAMES) : NW'(count_ext);
      frame_idx_d = '0;
      ramp_l_d    = $signed({1'b0, clamp_gain(in_gsl), 16'h0000});
      ramp_r_d    = in_stereo ? $signed({1'b0, clamp_gain(in_gsr), 16'h0000})
                              : $signed({1'b0, clamp_gain(in_gsl), 16'h0000});
      step_l_d    = '0;
      step_r_d    = '0;
    end

    if (cmd_i.div_start) begin
      div_neg_d = gain_diff[GW];
    end

    if (cmd_i.step_store) begin
      if (cmd_i.div_right) begin
        step_r_d = step_res;
      end else begin
        step_l_d = step_res;
        if (!stereo_q) begin
          step_r_d = step_res;
        end
      end
    end

    if (cmd_i.mix_issue) begin
      prod_l_d = in_sl * $signed({1'b0, gain_l});
      prod_r_d = samp_r * $signed({1'b0, gain_r});
      idx_d    = frame_idx_q[AW-1:0];
    end

    if (cmd_i.mix_commit) begin
      out_data_d                     = '0;
      out_data_d[ML_LSB +: MIX_W]    = sat_l;
      out_data_d[MR_LSB +: MIX_W]    = sat_r;
      out_data_d[POS_LSB +: POS_W]   = POS_W'(idx_q);
      out_valid_d                    = 1'b1;
      ramp_l_d                       = ramp_l_q + step_l_q;
      ramp_r_d                       = ramp_r_q + step_r_q;
      frame_idx_d                    = frame_idx_q + NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stereo_q    <= 1'b0;
      chunk_len_q <= '0;
      frame_idx_q <= '0;
      out_valid_q <= 1'b0;
      clr_addr_q  <= '0;
    end else begin
      stereo_q    <= stereo_d;
      chunk_len_q <= chunk_len_d;
      frame_idx_q <= frame_idx_d;
      out_valid_q <= out_valid_d;
      clr_addr_q  <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gl0_q      <= gl0_d;
    gl1_q      <= gl1_d;
    gr0_q      <= gr0_d;
    gr1_q      <= gr1_d;
    ramp_l_q   <= ramp_l_d;
    ramp_r_q   <= ramp_r_d;
    step_l_q   <= step_l_d;
    step_r_q   <= step_r_d;
    div_neg_q  <= div_neg_d;
    prod_l_q   <= prod_l_d;
    prod_r_q   <= prod_r_d;
    idx_q      <= idx_d;
    out_data_q <= out_data_d;
  end

  assign status_o.active   = (frame_idx_q < chunk_len_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.div_done = div_done;
  assign status_o.clr_last = (clr_addr_q == AW'(PACKET_FRAMES - 1));
  assign status_o.stereo   = stereo_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: hw/rtl/grma_ctrl.sv
// Controller state machine: input handshake, clear sweep, ramp division
// sequencing and frame commit. Depends on grma_pkg.
module grma_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [grma_pkg::FUNC_W-1:0]   func_i,
  output logic                          in_ready_o,
  input  grma_pkg::dp_status_t          status_i,
  output grma_pkg::dp_cmd_t             cmd_o
);

  import grma_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (func_i)
            FUNC_BEGIN: state_d = ST_DIV_L_GO;
            FUNC_MIX:   state_d = status_i.active ? ST_MIX : ST_IDLE;
            FUNC_CLEAR: state_d = ST_CLEAR;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_MIX: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV_L_GO: state_d = ST_DIV_L_WAIT;
      ST_DIV_L_WAIT: begin
        if (status_i.div_done) begin
          state_d = status_i.stereo ? ST_DIV_R_GO : ST_IDLE;
        end
      end
      ST_DIV_R_GO: state_d = ST_DIV_R_WAIT;
      ST_DIV_R_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_write = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (func_i)
            FUNC_BEGIN: cmd_o.begin_load = 1'b1;
            FUNC_MIX:   cmd_o.mix_issue  = status_i.active;
            FUNC_CLEAR: cmd_o            = '0;
            default:    cmd_o            = '0;
          endcase
        end
      end
      ST_MIX: cmd_o.mix_commit = status_i.out_free;
      ST_DIV_L_GO: cmd_o.div_start = 1'b1;
      ST_DIV_L_WAIT: cmd_o.step_store = status_i.div_done;
      ST_DIV_R_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_right = 1'b1;
      end
      ST_DIV_R_WAIT: begin
        cmd_o.div_right  = 1'b1;
        cmd_o.step_store = status_i.div_done;
      end
      default: cmd_o = '0;
    endcase
  end

  // The store is swept to zero after reset before the first transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/grma_checker.sv
// Port-level assertions for the gain ramp mix accumulator, bound to the top level.
// Depends on grma_pkg and gain_ramp_mix_accumulator_defines.svh.
`include "gain_ramp_mix_accumulator_defines.svh"

module grma_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  // func
  input logic [grma_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  // mix_left, mix_right, frame_position
  input logic [grma_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  import grma_pkg::*;

  logic in_xact;

  assign in_xact = s_axis_tvalid && s_axis_tready;

  // A stalled result must hold.
  `GRMA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // A clear transaction starts the sweep, which blocks the input.
  `GRMA_ASSERT_NEXT(a_clear_blocks, in_xact && s_axis_tuser == FUNC_CLEAR, !s_axis_tready, "input open during clear sweep")

  // A begin transaction starts the ramp division, which blocks the input.
  `GRMA_ASSERT_NEXT(a_begin_blocks, in_xact && s_axis_tuser == FUNC_BEGIN, !s_axis_tready, "input open during ramp division")

  // A new result is only produced by the accumulate step, when the input is closed.
  `GRMA_ASSERT_IMP(a_result_origin, $rose(m_axis_tvalid), $past(!s_axis_tready), "result appeared outside the accumulate step")

endmodule

bind gain_ramp_mix_accumulator grma_checker u_grma_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench for gain_ramp_mix_accumulator: a directed stimulus table, then random
// chunk traffic; results are checked against table outcomes or an in-bench ramped mix store model.
// Depends on grma_pkg and the gain_ramp_mix_accumulator RTL.
`timescale 1ns / 100ps

module tb_top;
  import grma_pkg::*;

  localparam int     STORE_DEPTH  = 512;
  localparam longint UNITY        = 4096;
  localparam longint RAMP_ONE     = 65536;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int     IDLE_LIMIT   = 4000;
  localparam int     LONG_HOLD    = 300;
  localparam int     TARGET_ITEMS = 800;
  localparam int     DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [FUNC_W-1:0]          func;
    logic [GAIN_W-1:0]          gain_start_left;
    logic [GAIN_W-1:0]          gain_end_left;
    logic [GAIN_W-1:0]          gain_start_right;
    logic [GAIN_W-1:0]          gain_end_right;
    logic [COUNT_W-1:0]         frame_count;
    logic                       stereo;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
  } mix_item_t;

  typedef struct packed {
    logic signed [MIX_W-1:0] mix_left;
    logic signed [MIX_W-1:0] mix_right;
    logic [POS_W-1:0]        frame_position;
  } mix_result_t;

  typedef struct {
    mix_item_t   it;
    bit          typed;
    mix_result_t res;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Model of the block: mix stores, ramps and chunk position.
  int     mix_left_store [STORE_DEPTH];
  int     mix_right_store[STORE_DEPTH];
  longint ramp_left, ramp_right, step_left, step_right;
  int     next_frame, chunk_frames;
  bit     chunk_stereo;

  mix_result_t expected_mix_q[$];
  stim_row_t   stim_table[$];
  mix_result_t no_result = '0;
  int          mismatches = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;

  gain_ramp_mix_accumulator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clamp_gain(input logic [GAIN_W-1:0] g);
    return (longint'(g) > UNITY) ? UNITY : longint'(g);
  endfunction

  function automatic longint ramp_slope(input longint g0, input longint g1, input int n);
    // Signed division in SystemVerilog truncates toward zero.
    return (n == 0) ? 0 : ((g1 - g0) * RAMP_ONE) / longint'(n);
  endfunction

  function automatic int sat32(input int acc, input longint add);
    longint s;
    s = longint'(acc) + add;
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return int'(s);
  endfunction

  function automatic bit predict_mix(input mix_item_t it, output mix_result_t res);
    longint gl0, gl1, gr0, gr1, pl, pr;
    int     n, pos;
    res = '0;
    case (it.func)
      FUNC_BEGIN: begin
        gl0 = clamp_gain(it.gain_start_left);
        gl1 = clamp_gain(it.gain_end_left);
        gr0 = clamp_gain(it.gain_start_right);
        gr1 = clamp_gain(it.gain_end_right);
        n = (it.frame_count > STORE_DEPTH) ? STORE_DEPTH : int'(it.frame_count);
        chunk_stereo = it.stereo;
        chunk_frames = n;
        next_frame = 0;
        ramp_left = gl0 * RAMP_ONE;
        step_left = ramp_slope(gl0, gl1, n);
        if (chunk_stereo) begin
          ramp_right = gr0 * RAMP_ONE;
          step_right = ramp_slope(gr0, gr1, n);
        end else begin
          ramp_right = ramp_left;
          step_right = step_left;
        end
        return 1'b0;
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
          mix_left_store[i] = 0;
          mix_right_store[i] = 0;
        end
        return 1'b0;
      end
      FUNC_MIX: begin
        if (next_frame >= chunk_frames) return 1'b0;
        pos = next_frame;
        pl = longint'(it.sample_left) * (ramp_left / RAMP_ONE);
        pr = chunk_stereo ? longint'(it.sample_right) * (ramp_right / RAMP_ONE) : pl;
        mix_left_store[pos] = sat32(mix_left_store[pos], pl);
        mix_right_store[pos] = sat32(mix_right_store[pos], pr);
        res.mix_left = mix_left_store[pos];
        res.mix_right = mix_right_store[pos];
        res.frame_position = 9'(pos);
        ramp_left += step_left;
        ramp_right += step_right;
        next_frame = pos + 1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_item(input mix_item_t it);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[GSL_LSB +: GAIN_W]      = it.gain_start_left;
    d[GEL_LSB +: GAIN_W]      = it.gain_end_left;
    d[GSR_LSB +: GAIN_W]      = it.gain_start_right;
    d[GER_LSB +: GAIN_W]      = it.gain_end_right;
    d[COUNT_LSB +: COUNT_W]   = it.frame_count;
    d[STEREO_LSB]             = it.stereo;
    d[SL_LSB +: SAMPLE_W]     = it.sample_left;
    d[SR_LSB +: SAMPLE_W]     = it.sample_right;
    return d;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    if ($urandom_range(0, 4) == 0) return 13'($urandom);
    return 13'($urandom_range(0, 4096));
  endfunction

  function automatic mix_item_t rand_item();
    mix_item_t it;
    it.func             = 2'($urandom_range(0, 3));
    it.gain_start_left  = rand_gain();
    it.gain_end_left    = rand_gain();
    it.gain_start_right = rand_gain();
    it.gain_end_right   = rand_gain();
    it.frame_count      = 10'($urandom_range(0, 1023));
    it.stereo           = 1'($urandom);
    it.sample_left      = rand_sample();
    it.sample_right     = rand_sample();
    return it;
  endfunction

  function automatic mix_item_t mk_item(input logic [FUNC_W-1:0] func,
                                        input int gsl, input int gel, input int gsr,
                                        input int ger, input int cnt, input bit st,
                                        input int sl, input int sr);
    mix_item_t it;
    it = rand_item();
    it.func = func;
    if (func == FUNC_BEGIN) begin
      it.gain_start_left  = 13'(gsl);
      it.gain_end_left    = 13'(gel);
      it.gain_start_right = 13'(gsr);
      it.gain_end_right   = 13'(ger);
      it.frame_count      = 10'(cnt);
      it.stereo           = st;
    end
    if (func == FUNC_MIX) begin
      it.sample_left  = 16'(sl);
      it.sample_right = 16'(sr);
    end
    return it;
  endfunction

  function automatic mix_result_t outcome(input int l, input int r, input int p);
    mix_result_t res;
    res.mix_left = l;
    res.mix_right = r;
    res.frame_position = 9'(p);
    return res;
  endfunction

  task automatic wait_drained();
    while (expected_mix_q.size() != 0) @(posedge clk_i);
  endtask

  // Offers one transaction and, once it is taken, records what it should produce.
  task automatic offer(input mix_item_t it, input bit typed, input mix_result_t typed_res);
    int          gap;
    bit          has_res;
    mix_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_item(it);
    s_axis_tuser  <= it.func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    has_res = predict_mix(it, res);
    if (has_res) expected_mix_q.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  task automatic run_chunk(input logic [COUNT_W-1:0] cnt, input int frames);
    mix_item_t it;
    it = rand_item();
    it.func = FUNC_BEGIN;
    it.frame_count = cnt;
    offer(it, 1'b0, no_result);
    repeat (frames) begin
      it = rand_item();
      it.func = FUNC_MIX;
      offer(it, 1'b0, no_result);
    end
  endtask

  // Repeated full-gain single-frame chunks pile extreme products onto frame zero.
  task automatic run_saturation(input bit negative);
    mix_item_t it;
    repeat (20) begin
      it = rand_item();
      it.func = FUNC_BEGIN;
      it.gain_start_left = 13'd4096;
      it.gain_start_right = 13'd4096;
      it.frame_count = 10'd1;
      offer(it, 1'b0, no_result);
      it = rand_item();
      it.func = FUNC_MIX;
      it.sample_left = negative ? 16'h8000 : 16'h7fff;
      it.sample_right = it.sample_left;
      offer(it, 1'b0, no_result);
    end
  endtask

  // Result side: random stalls, one long hold-off on request, field-by-field checks.
  initial begin
    int          stall;
    mix_result_t got, exp_res;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        stall = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got.mix_left       = m_axis_tdata[ML_LSB +: MIX_W];
      got.mix_right      = m_axis_tdata[MR_LSB +: MIX_W];
      got.frame_position = m_axis_tdata[POS_LSB +: POS_W];
      if (expected_mix_q.size() == 0) begin
        $error("unexpected result at frame_position %0d", got.frame_position);
        mismatches++;
      end else begin
        exp_res = expected_mix_q.pop_front();
        if (got.mix_left !== exp_res.mix_left) begin
          $error("mix_left: expected %0d, got %0d", exp_res.mix_left, got.mix_left);
          mismatches++;
        end
        if (got.mix_right !== exp_res.mix_right) begin
          $error("mix_right: expected %0d, got %0d", exp_res.mix_right, got.mix_right);
          mismatches++;
        end
        if (got.frame_position !== exp_res.frame_position) begin
          $error("frame_position: expected %0d, got %0d",
                 exp_res.frame_position, got.frame_position);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int               pick, frames, n, long_runs_left, sat_runs_left;
    bit               sat_negative;
    logic [COUNT_W-1:0] cnt;
    mix_item_t        it;

    for (int i = 0; i < STORE_DEPTH; i++) begin
      mix_left_store[i] = 0;
      mix_right_store[i] = 0;
    end
    ramp_left = 0; ramp_right = 0; step_left = 0; step_right = 0;
    next_frame = 0; chunk_frames = 0; chunk_stereo = 1'b0;
    long_runs_left = 1;
    sat_runs_left = 2;
    sat_negative = 1'b1;

    // Directed table: func, gains (start/end left, start/end right), count, stereo, samples.
    stim_table.push_back('{mk_item(FUNC_MIX, 0, 0, 0, 0, 0, 0, 32767, 0), 1'b0, no_result});
    stim_table.push_back('{mk_item(FUNC_BEGIN, 4096, 4096, 0, 0, 2, 0, 0, 0), 1'b0, no_result});
    stim_table.push_back('{mk_item(FUNC_MIX, 0, 0, 0, 0, 0, 0, 32767, 5), 1'b1,
                           outcome(134213632, 134213632, 0)});
    stim_table.push_back('{mk_item(FUNC_MIX, 0, 0, 0, 0, 0, 0, -32768, 5), 1'b1,
                           outcome(-134217728, -134217728, 1)});
    stim_table.push_back('{mk_item(FUNC_MIX, 0, 0, 0, 0, 0, 0, 1, 1), 1'b0, no_result});
    // Gains above unity clamp, and a count beyond the store depth saturates.
    stim_table.push_back('{mk_item(FUNC_BEGIN, 8191, 0, 0, 8191, 1023, 1, 0, 0), 1'b0,
                           no_result});
    stim_table.push_back('{mk_item(FUNC_MIX, 0, 0, 0, 0, 0, 0, -32768, 32767), 1'b1,
                           outcome(-4096, 134213632, 0)});
    stim_table.push_back('{mk_item(FUNC_MIX, 0, 0, 0, 0, 0, 0, 32767, -32768), 1'b0,
                           no_result});
    stim_table.push_back('{mk_item(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, no_result});
    stim_table.push_back('{mk_item(FUNC_MIX, 0, 0, 0, 0, 0, 0, -12345, 23456), 1'b0,
                           no_result});
    stim_table.push_back('{mk_item(FUNC_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, no_result});
    // A zero count opens no chunk at all.
    stim_table.push_back('{mk_item(FUNC_BEGIN, 4096, 4096, 4096, 4096, 0, 0, 0, 0), 1'b0,
                           no_result});
    stim_table.push_back('{mk_item(FUNC_MIX, 0, 0, 0, 0, 0, 0, 32767, 32767), 1'b0,
                           no_result});
    stim_table.push_back('{mk_item(FUNC_BEGIN, 4096, 0, 4096, 4096, 1, 1, 0, 0), 1'b0,
                           no_result});
    stim_table.push_back('{mk_item(FUNC_MIX, 0, 0, 0, 0, 0, 0, 0, -32768), 1'b1,
                           outcome(0, -134217728, 0)});
    stim_table.push_back('{mk_item(FUNC_MIX, 0, 0, 0, 0, 0, 0, 7, 7), 1'b0, no_result});
    // Mono: right gains and the right sample are ignored.
    stim_table.push_back('{mk_item(FUNC_BEGIN, 1, 1, 8191, 0, 3, 0, 0, 0), 1'b0, no_result});
    stim_table.push_back('{mk_item(FUNC_MIX, 0, 0, 0, 0, 0, 0, -1, 32767), 1'b1,
                           outcome(-1, -134217729, 0)});
    stim_table.push_back('{mk_item(FUNC_MIX, 0, 0, 0, 0, 0, 0, 32767, -32768), 1'b1,
                           outcome(32767, 32767, 1)});
    // A new chunk replaces the open one from frame zero.
    stim_table.push_back('{mk_item(FUNC_BEGIN, 0, 4096, 0, 0, 512, 0, 0, 0), 1'b0,
                           no_result});
    stim_table.push_back('{mk_item(FUNC_MIX, 0, 0, 0, 0, 0, 0, 32767, 100), 1'b1,
                           outcome(-1, -134217729, 0)});
    stim_table.push_back('{mk_item(FUNC_MIX, 0, 0, 0, 0, 0, 0, -32768, 100), 1'b0,
                           no_result});
    // Falling ramp: the step division truncates toward zero.
    stim_table.push_back('{mk_item(FUNC_BEGIN, 100, 0, 0, 100, 7, 1, 0, 0), 1'b0,
                           no_result});
    stim_table.push_back('{mk_item(FUNC_MIX, 0, 0, 0, 0, 0, 0, 32767, -32768), 1'b0,
                           no_result});
    stim_table.push_back('{mk_item(FUNC_MIX, 0, 0, 0, 0, 0, 0, -20000, 30000), 1'b0,
                           no_result});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_table[i]) offer(stim_table[i].it, stim_table[i].typed, stim_table[i].res);

    // Hold the sender until the directed results are all back.
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // Back-to-back frames against a receiver that holds off for a long stretch.
    hold_req = 1'b1;
    no_idle = 1'b1;
    run_chunk(10'd40, 40);
    no_idle = 1'b0;

    while (items_sent < TARGET_ITEMS) begin
      if ($urandom_range(0, 7) == 0) no_idle = ~no_idle;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        case ($urandom_range(0, 19))
          0:       cnt = 10'd0;
          1:       cnt = 10'($urandom_range(25, 120));
          2:       cnt = 10'($urandom_range(121, 1023));
          default: cnt = 10'($urandom_range(1, 24));
        endcase
        n = (cnt > STORE_DEPTH) ? STORE_DEPTH : int'(cnt);
        if (cnt > 120) begin
          // Only one long chunk runs deep into the store; the others are cut short.
          frames = (long_runs_left > 0) ? $urandom_range(256, 300) : $urandom_range(0, 40);
          if (long_runs_left > 0) long_runs_left--;
        end else if ($urandom_range(0, 6) == 0) begin
          frames = $urandom_range(0, n);
        end else begin
          frames = n + $urandom_range(0, 2);
        end
        run_chunk(cnt, frames);
      end else if (pick < 75 && sat_runs_left > 0) begin
        run_saturation(sat_negative);
        sat_negative = ~sat_negative;
        sat_runs_left--;
      end else if (pick < 85) begin
        it = rand_item();
        it.func = FUNC_CLEAR;
        offer(it, 1'b0, no_result);
      end else begin
        it = rand_item();
        it.func = ($urandom_range(0, 1) == 0) ? FUNC_UNUSED : FUNC_MIX;
        offer(it, 1'b0, no_result);
      end
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/grma_pkg.sv
hw/rtl/grma_ram.sv
hw/rtl/grma_divider.sv
hw/rtl/grma_datapath.sv
hw/rtl/grma_ctrl.sv
hw/rtl/gain_ramp_mix_accumulator.sv
hw/rtl/grma_checker.sv
tb/tb_top.sv
